FILE: hdl/hkvt_pkg.sv
`default_nettype none
package hkvt_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_TAKE   = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_TABLE_EMPTY = 3'd2,
    ST_BUCKET_EMPTY = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } status_t;

  // Command driven by the controller to all cells for one cycle.
  typedef struct packed {
    logic wr_val;    // write value into the selected slot
    logic ins;       // insert key, value and bucket into the selected slot
    logic clr;       // free the selected slot
    logic flush;     // free every slot
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/hkvt_cell.sv
`default_nettype none
module hkvt_cell #(
  parameter int IDX_W = 4,
  parameter int VAL_W = 32,
  parameter int KEY_W = 64
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire logic [IDX_W-1:0]     my_idx,
  input  wire hkvt_pkg::cell_cmd_t  cmd,
  input  wire logic [IDX_W-1:0]     sel_idx,
  input  wire logic [KEY_W-1:0]     wr_key,
  input  wire logic [VAL_W-1:0]     wr_value,
  input  wire logic [IDX_W-1:0]     wr_bucket,
  // Search token moving along the chain.
  input  wire logic                 prev_found,
  input  wire logic [IDX_W-1:0]     prev_hit,
  input  wire logic                 prev_free_ok,
  input  wire logic [IDX_W-1:0]     prev_free,
  input  wire logic [VAL_W-1:0]     prev_value,
  output logic                      next_found,
  output logic [IDX_W-1:0]          next_hit,
  output logic                      next_free_ok,
  output logic [IDX_W-1:0]          next_free,
  output logic [VAL_W-1:0]          next_value
);

  logic             used_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic [IDX_W-1:0] bucket_r;
  logic             match;

  // Slot state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (cmd.flush) begin
      used_r <= 1'b0;
    end else if (sel_idx == my_idx) begin
      if (cmd.ins) used_r <= 1'b1;
      else if (cmd.clr) used_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_idx == my_idx && (cmd.ins || cmd.wr_val)) begin
      value_r <= wr_value;
    end
    if (sel_idx == my_idx && cmd.ins) begin
      key_r    <= wr_key;
      bucket_r <= wr_bucket;
    end
  end

  // Compare against the search key and pass the token on.
  assign match = used_r && bucket_r == wr_bucket && key_r == wr_key;

  always_ff @(posedge clk) begin
    if (!prev_found && match) begin
      next_found <= 1'b1;
      next_hit   <= my_idx;
      next_value <= value_r;
    end else begin
      next_found <= prev_found;
      next_hit   <= prev_hit;
      next_value <= prev_value;
    end
    if (!prev_free_ok && !used_r) begin
      next_free_ok <= 1'b1;
      next_free    <= my_idx;
    end else begin
      next_free_ok <= prev_free_ok;
      next_free    <= prev_free;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hashed_key_value_table.sv
`default_nettype none
// Hashed key-value table with TABLE_SIZE slots in a chain of slot cells.
// Input channel: drive in_op, in_key and in_write_value with start high while
// busy is low; that edge accepts the beat. Each command yields exactly one
// result beat: out_status and out_read_value are shown for one cycle with
// out_valid high. The receiver cannot stall.
// Steps: byte-wise FNV-1a hashing (one multiply per cycle; all eight key
// bytes are always walked, whatever KEY_BYTES is), then a scan while a
// search token walks the cell chain (all cells are stable while it walks),
// then an update state and a result state. busy stays high until the result
// cycle ends, so a new command is taken only after the previous result; one
// item is in work at once. Flush takes the same path as every other command.
// Reset (synchronous, rst_n low) frees every slot and clears all counts;
// key and value storage is not cleared.
// read_value is zero for put, flush and every failed lookup.
module hashed_key_value_table #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire logic [1:0]   in_op,
  input  wire logic [63:0]  in_key,
  input  wire logic [31:0]  in_write_value,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [31:0]       out_read_value
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int VAL_W = VALUE_BITS > 32 ? 32 : VALUE_BITS;
  // The byte counter always walks all eight key bytes.
  localparam int BYTE_W = 3;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_SCAN, S_EXEC, S_DONE
  } state_t;

  state_t              state_r;
  logic [1:0]          op_r;
  logic [63:0]         key_r;
  logic [VAL_W-1:0]    val_r;
  logic [31:0]         hash_r;
  logic [BYTE_W-1:0]   byte_r;
  logic                stop_r;
  logic [IDX_W:0]      step_r;
  logic [CNT_W-1:0]    stored_r;
  logic [CNT_W-1:0]    bcount_r [TABLE_SIZE];
  logic [2:0]          status_r;
  logic [31:0]         rd_r;
  logic                out_valid_r;

  hkvt_pkg::cell_cmd_t cmd;
  logic [IDX_W-1:0]    sel_idx;
  logic [IDX_W-1:0]    bucket;
  logic [7:0]          cur_byte;
  logic [31:0]         hash_x;

  logic                 c_found [TABLE_SIZE+1];
  logic [IDX_W-1:0]     c_hit   [TABLE_SIZE+1];
  logic                 c_fok   [TABLE_SIZE+1];
  logic [IDX_W-1:0]     c_free  [TABLE_SIZE+1];
  logic [VAL_W-1:0]     c_val   [TABLE_SIZE+1];

  assign bucket   = hash_r[IDX_W-1:0];
  assign cur_byte = key_r[8*byte_r[2:0] +: 8];
  assign hash_x   = hash_r ^ {24'd0, cur_byte};

  assign c_found[0] = 1'b0;
  assign c_hit[0]   = '0;
  assign c_fok[0]   = 1'b0;
  assign c_free[0]  = '0;
  assign c_val[0]   = '0;

  // Row of slot cells; the search token advances one cell per cycle.
  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    hkvt_cell #(.IDX_W(IDX_W), .VAL_W(VAL_W), .KEY_W(64)) u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IDX_W'(g)), .cmd(cmd),
      .sel_idx(sel_idx), .wr_key(key_r), .wr_value(val_r), .wr_bucket(bucket),
      .prev_found(c_found[g]), .prev_hit(c_hit[g]), .prev_free_ok(c_fok[g]),
      .prev_free(c_free[g]), .prev_value(c_val[g]),
      .next_found(c_found[g+1]), .next_hit(c_hit[g+1]),
      .next_free_ok(c_fok[g+1]), .next_free(c_free[g+1]),
      .next_value(c_val[g+1])
    );
  end

  // Cell command for the update cycle.
  always_comb begin
    cmd     = '0;
    sel_idx = c_found[TABLE_SIZE] ? c_hit[TABLE_SIZE] : c_free[TABLE_SIZE];
    if (state_r == S_EXEC) begin
      unique case (hkvt_pkg::op_t'(op_r))
        hkvt_pkg::OP_PUT: begin
          if (stored_r < CNT_W'(TABLE_SIZE)) begin
            cmd.wr_val = c_found[TABLE_SIZE];
            cmd.ins    = !c_found[TABLE_SIZE] && c_fok[TABLE_SIZE];
          end
        end
        hkvt_pkg::OP_FLUSH: cmd.flush = 1'b1;
        hkvt_pkg::OP_GET: ;
        hkvt_pkg::OP_TAKE: begin
          cmd.clr = stored_r != '0 && bcount_r[bucket] != '0 && c_found[TABLE_SIZE];
        end
        default: ;
      endcase
    end
  end

  // Controller: hash, scan, update, respond.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TABLE_SIZE; i++) bcount_r[i] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_op;
            key_r   <= in_key;
            val_r   <= in_write_value[VAL_W-1:0];
            hash_r  <= hkvt_pkg::FNV_BASIS;
            byte_r  <= '0;
            stop_r  <= 1'b0;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          // Normalize the key and fold in one byte per cycle.
          if (stop_r || cur_byte == 8'd0) begin
            stop_r <= 1'b1;
            key_r[8*byte_r[2:0] +: 8] <= 8'd0;
          end else begin
            hash_r <= hash_x * hkvt_pkg::FNV_PRIME;
          end
          if (byte_r == BYTE_W'(7)) begin
            state_r <= S_SCAN;
            step_r  <= '0;
          end else if (byte_r == BYTE_W'(KEY_BYTES - 1)) begin
            stop_r <= 1'b1;
          end
          byte_r <= byte_r + 1'b1;
        end
        S_SCAN: begin
          step_r <= step_r + 1'b1;
          if (step_r == (IDX_W+1)'(TABLE_SIZE)) state_r <= S_EXEC;
        end
        S_EXEC: begin
          status_r <= hkvt_pkg::ST_OK;
          rd_r     <= '0;
          unique case (hkvt_pkg::op_t'(op_r))
            hkvt_pkg::OP_PUT: begin
              if (stored_r >= CNT_W'(TABLE_SIZE)) begin
                status_r <= hkvt_pkg::ST_FULL;
              end else if (!c_found[TABLE_SIZE]) begin
                if (c_fok[TABLE_SIZE]) begin
                  bcount_r[bucket] <= bcount_r[bucket] + 1'b1;
                  stored_r <= stored_r + 1'b1;
                end else begin
                  status_r <= hkvt_pkg::ST_FULL;
                end
              end
            end
            hkvt_pkg::OP_FLUSH: begin
              stored_r <= '0;
              for (int i = 0; i < TABLE_SIZE; i++) bcount_r[i] <= '0;
            end
            default: begin
              if (stored_r == '0) begin
                status_r <= hkvt_pkg::ST_TABLE_EMPTY;
              end else if (bcount_r[bucket] == '0) begin
                status_r <= hkvt_pkg::ST_BUCKET_EMPTY;
              end else if (!c_found[TABLE_SIZE]) begin
                status_r <= hkvt_pkg::ST_NOT_FOUND;
              end else begin
                rd_r <= 32'(c_val[TABLE_SIZE]);
                if (op_r == hkvt_pkg::OP_TAKE) begin
                  bcount_r[bucket] <= bcount_r[bucket] - 1'b1;
                  stored_r <= stored_r - 1'b1;
                end
              end
            end
          endcase
          out_valid_r <= 1'b1;
          state_r     <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rd_r;

  // The item count never exceeds the table size.
  assert property (@(posedge clk) disable iff (!rst_n) stored_r <= CNT_W'(TABLE_SIZE))
    else $error("stored count overflow");
  // A result follows the update cycle.
  assert property (@(posedge clk) disable iff (!rst_n) state_r == S_EXEC |=> out_valid)
    else $error("missing result");
  // No result while idle-to-scan work is still underway.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HASH || state_r == S_SCAN) |-> !out_valid_r)
    else $error("early result");

endmodule
`default_nettype wire

FILE: tb/table_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module table_checker
  import hkvt_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire         busy,
  input  wire  [1:0]  in_op,
  input  wire  [63:0] in_key,
  input  wire  [31:0] in_write_value,
  input  wire         out_valid,
  input  wire  [2:0]  out_status,
  input  wire  [31:0] out_read_value,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam int SLOTS = 16;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } answer_t;

  // Shadow copy of the table contents.
  logic        used_q   [SLOTS];
  logic [63:0] key_q    [SLOTS];
  logic [31:0] value_q  [SLOTS];
  logic [3:0]  bucket_q [SLOTS];
  int          chain_len [SLOTS];
  int          occupancy;
  answer_t     answer_fifo [$];

  // Cut the key at its first zero byte and return the length.
  function automatic logic [63:0] trim_key(input logic [63:0] raw, output int len);
    logic [63:0] k;
    k = '0;
    len = 8;
    for (int i = 0; i < 8; i++) begin
      if (raw[8*i +: 8] == 8'h00) begin
        len = i;
        break;
      end
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic logic [3:0] bucket_of(input logic [63:0] k, input int len);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
    end
    return h[3:0];
  endfunction

  function automatic int slot_of(input logic [63:0] k, input logic [3:0] b);
    for (int i = 0; i < SLOTS; i++)
      if (used_q[i] && bucket_q[i] == b && key_q[i] == k) return i;
    return -1;
  endfunction

  // Apply one command to the shadow table and return the answer it should give.
  function automatic answer_t apply_command(input op_t op, input logic [63:0] raw,
                                            input logic [31:0] wv);
    answer_t a;
    int len, s;
    logic [63:0] k;
    logic [3:0] b;
    a.status = ST_OK;
    a.value = '0;
    k = trim_key(raw, len);
    b = bucket_of(k, len);
    case (op)
      OP_PUT: begin
        if (occupancy >= SLOTS) begin
          a.status = ST_FULL;
        end else begin
          s = slot_of(k, b);
          if (s >= 0) begin
            value_q[s] = wv;
          end else begin
            for (s = 0; s < SLOTS; s++)
              if (!used_q[s]) break;
            used_q[s] = 1'b1;
            key_q[s] = k;
            value_q[s] = wv;
            bucket_q[s] = b;
            chain_len[b]++;
            occupancy++;
          end
        end
      end
      OP_FLUSH: begin
        for (int i = 0; i < SLOTS; i++) begin
          used_q[i] = 1'b0;
          chain_len[i] = 0;
        end
        occupancy = 0;
      end
      default: begin
        if (occupancy == 0) begin
          a.status = ST_TABLE_EMPTY;
        end else if (chain_len[b] == 0) begin
          a.status = ST_BUCKET_EMPTY;
        end else begin
          s = slot_of(k, b);
          if (s < 0) begin
            a.status = ST_NOT_FOUND;
          end else begin
            a.value = value_q[s];
            if (op == OP_TAKE) begin
              used_q[s] = 1'b0;
              chain_len[b]--;
              occupancy--;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Clear the shadow table in reset; otherwise predict on each accepted
  // command beat and check each result beat.
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      occupancy = 0;
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i] = 1'b0;
        chain_len[i] = 0;
      end
      answer_fifo.delete();
    end else begin
      if (out_valid) begin
        result_count++;
        if (answer_fifo.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_a = answer_fifo.pop_front();
          if (out_status !== exp_a.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_a.status));
          if (out_read_value !== exp_a.value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      out_read_value, exp_a.value));
        end
      end
      if (start && !busy)
        answer_fifo.push_back(apply_command(op_t'(in_op), in_key, in_write_value));
    end
    pending_count = answer_fifo.size();
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import hkvt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_op = OP_GET;
  logic [63:0] in_key = '0;
  logic [31:0] in_write_value = '0;
  wire         busy, out_valid;
  wire  [2:0]  out_status;
  wire  [31:0] out_read_value;
  int          fail_count, pending_count, result_count;
  logic [63:0] key_pool [12];

  always #5 clk = ~clk;

  hashed_key_value_table dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_key, .in_write_value,
    .out_valid, .out_status, .out_read_value
  );

  table_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_op, .in_key, .in_write_value,
    .out_valid, .out_status, .out_read_value,
    .fail_count, .pending_count, .result_count
  );

  // Present one command beat and hold it until the block takes it.
  task automatic issue(input op_t op, input logic [63:0] key, input logic [31:0] wv);
    in_op = op;
    in_key = key;
    in_write_value = wv;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Random key: short strings, embedded zeros, or full-width noise.
  function automatic logic [63:0] random_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: k = k & ((64'd1 << (8 * $urandom_range(0, 7))) - 1);
      1: k[8*$urandom_range(0, 7) +: 8] = 8'h00;
      default: ;
    endcase
    return k;
  endfunction

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int n;
    op_t op;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty table, empty key, extremes, full table, flush.
    issue(OP_GET, 64'h0, '1);
    issue(OP_TAKE, 64'h41, 0);
    issue(OP_FLUSH, 64'h0, 0);
    issue(OP_PUT, 64'h0, 32'hFFFF_FFFF);
    issue(OP_GET, 64'hFF00_0000_0000_0000, 0);
    issue(OP_PUT, '1, 32'h0);
    issue(OP_GET, '1, 0);
    issue(OP_GET, 64'h61, 0);
    issue(OP_GET, 64'h6261, 0);
    for (int i = 1; i <= 14; i++) issue(OP_PUT, 64'h30 + i, i);
    issue(OP_PUT, 64'h0, 32'h1234);
    issue(OP_PUT, 64'h7A7A, 5);
    issue(OP_TAKE, 64'h31, 0);
    issue(OP_TAKE, 64'h31, 0);
    issue(OP_FLUSH, 64'h0, 0);

    for (int i = 0; i < 12; i++) key_pool[i] = random_key();
    // Random traffic on a small key pool so hits, fills and removals occur.
    n = 0;
    while (n < 900) begin
      if (n < 750 && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
      case ($urandom_range(0, 39))
        0: op = OP_FLUSH;
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: op = OP_PUT;
        15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26: op = OP_GET;
        default: op = OP_TAKE;
      endcase
      if ($urandom_range(0, 9) < 7) issue(op, key_pool[$urandom_range(0, 11)], $urandom);
      else issue(op, random_key(), $urandom);
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, 11)] = random_key();
      n++;
    end

    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Ran %0d commands after the directed set; %0d result beats checked.", n,
             result_count);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/hkvt_pkg.sv
hdl/hkvt_cell.sv
hdl/hashed_key_value_table.sv
tb/table_checker.sv
tb/testbench.sv
